FILE: rtl/skct_pkg.sv
package skct_pkg;

  localparam int CAPACITY = 256;
  localparam int KEY_W    = 16;
  localparam int CNT_W    = 16;
  localparam int OCC_W    = 9;
  localparam int TOTAL_W  = $clog2(CAPACITY + 1);
  localparam int GROUP    = 16;
  localparam int NGRP     = (CAPACITY + GROUP - 1) / GROUP;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_ADD    = 2'd1;
  localparam logic [1:0] CMD_DEC    = 2'd2;
  localparam logic [1:0] CMD_LOOKUP = 2'd3;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_DUP     = 2'd1;
  localparam logic [1:0] STAT_MISSING = 2'd2;
  localparam logic [1:0] STAT_FULL    = 2'd3;

  typedef struct packed {
    logic [1:0]       command;
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] amount;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [CNT_W-1:0] count_after;
    logic [OCC_W-1:0] occupancy;
  } rsp_t;

  typedef struct packed {
    logic             cmp_en;
    logic             ins_do;
    logic             upd_do;
    logic [KEY_W-1:0] new_key;
    logic [CNT_W-1:0] new_cnt;
  } cell_ctrl_t;

endpackage

FILE: rtl/skct_cell.sv
module skct_cell (
  input  logic                    clk,
  input  skct_pkg::cell_ctrl_t    ctrl,
  input  logic                    valid,
  input  logic                    prev_lt,
  input  logic [skct_pkg::KEY_W-1:0] prev_key,
  input  logic [skct_pkg::CNT_W-1:0] prev_cnt,
  output logic                    lt_r,
  output logic                    eq_r,
  output logic [skct_pkg::KEY_W-1:0] key_r,
  output logic [skct_pkg::CNT_W-1:0] cnt_r
);
  import skct_pkg::*;

  always_ff @(posedge clk) begin
    if (ctrl.cmp_en) begin
      lt_r <= valid && (key_r < ctrl.new_key);
      eq_r <= valid && (key_r == ctrl.new_key);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ins_do) begin
      if (!prev_lt) begin
        key_r <= prev_key;
        cnt_r <= prev_cnt;
      end else if (!lt_r) begin
        key_r <= ctrl.new_key;
        cnt_r <= ctrl.new_cnt;
      end
    end else if (ctrl.upd_do && eq_r) begin
      cnt_r <= ctrl.new_cnt;
    end
  end

endmodule

FILE: rtl/skct_group.sv
module skct_group (
  input  logic                          clk,
  input  logic [skct_pkg::GROUP-1:0]    eq,
  input  logic [skct_pkg::CNT_W-1:0]    cnt [skct_pkg::GROUP],
  output logic                          found_r,
  output logic [skct_pkg::CNT_W-1:0]    cnt_r
);
  import skct_pkg::*;

  logic [CNT_W-1:0] cnt_sel;

  always_comb begin
    cnt_sel = '0;
    for (int j = 0; j < GROUP; j++) begin
      cnt_sel = cnt_sel | (eq[j] ? cnt[j] : '0);
    end
  end

  always_ff @(posedge clk) begin
    found_r <= |eq;
    cnt_r   <= cnt_sel;
  end

endmodule

FILE: rtl/sorted_key_count_table_core.sv
// Flow: an accepted request steps through compare, reduce and commit, and its result
// shows on the out_ ports with out_strobe high for one cycle, after the commit.
// No new request is taken while busy. Steps: broadcast compare in all cells, a two-level
// match reduction registered at the group level only, then commit with the neighbor shift of the cell row.
// Reset: occupancy and control return to empty and idle; key and count storage keeps
// whatever it held, and the receiver cannot stall the result.
module sorted_key_count_table_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  skct_pkg::req_t in_req,
  output logic           out_strobe,
  output skct_pkg::rsp_t out_rsp
);
  import skct_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_CMP    = 2'd1;
  localparam logic [1:0] ST_RED    = 2'd2;
  localparam logic [1:0] ST_COMMIT = 2'd3;

  logic [1:0]         state_r, state_nxt;
  req_t               req_r;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  rsp_t               rsp_r, rsp_nxt;
  logic               strobe_r, strobe_nxt;
  cell_ctrl_t         ctrl;

  logic [CAPACITY-1:0] c_lt, c_eq;
  logic [KEY_W-1:0]    c_key [CAPACITY];
  logic [CNT_W-1:0]    c_cnt [CAPACITY];

  logic [NGRP-1:0]     g_found;
  logic [CNT_W-1:0]    g_cnt [NGRP];

  logic               found;
  logic [CNT_W-1:0]   old_cnt;
  logic               full;
  logic [CNT_W:0]     sum;
  logic [CNT_W-1:0]   upd_cnt;
  logic               ins_ok;
  logic               upd_ok;

  assign busy = (state_r != ST_IDLE);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic             p_lt;
    logic [KEY_W-1:0] p_key;
    logic [CNT_W-1:0] p_cnt;
    if (i == 0) begin : g_head
      assign p_lt  = 1'b1;
      assign p_key = ctrl.new_key;
      assign p_cnt = ctrl.new_cnt;
    end else begin : g_link
      assign p_lt  = c_lt[i-1];
      assign p_key = c_key[i-1];
      assign p_cnt = c_cnt[i-1];
    end
    skct_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .valid    (total_r > TOTAL_W'(i)),
      .prev_lt  (p_lt),
      .prev_key (p_key),
      .prev_cnt (p_cnt),
      .lt_r     (c_lt[i]),
      .eq_r     (c_eq[i]),
      .key_r    (c_key[i]),
      .cnt_r    (c_cnt[i])
    );
  end

  for (genvar g = 0; g < NGRP; g++) begin : g_grp
    logic [GROUP-1:0] eq_in;
    logic [CNT_W-1:0] cnt_in [GROUP];
    for (genvar j = 0; j < GROUP; j++) begin : g_lane
      if (g * GROUP + j < CAPACITY) begin : g_used
        assign eq_in[j]  = c_eq[g*GROUP+j];
        assign cnt_in[j] = c_cnt[g*GROUP+j];
      end else begin : g_pad
        assign eq_in[j]  = 1'b0;
        assign cnt_in[j] = '0;
      end
    end
    skct_group u_group (
      .clk     (clk),
      .eq      (eq_in),
      .cnt     (cnt_in),
      .found_r (g_found[g]),
      .cnt_r   (g_cnt[g])
    );
  end

  always_comb begin
    old_cnt = '0;
    for (int g = 0; g < NGRP; g++) begin
      old_cnt = old_cnt | (g_found[g] ? g_cnt[g] : '0);
    end
  end

  assign found = |g_found;
  assign full  = (total_r == TOTAL_W'(CAPACITY));
  assign sum   = {1'b0, old_cnt} + {1'b0, req_r.amount};

  always_comb begin
    unique case (req_r.command)
      CMD_ADD:    upd_cnt = sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
      CMD_DEC:    upd_cnt = (old_cnt != '0) ? old_cnt - CNT_W'(1) : old_cnt;
      default:    upd_cnt = old_cnt;
    endcase
  end

  assign ins_ok = (req_r.command == CMD_INSERT) && !found && !full;
  assign upd_ok = ((req_r.command == CMD_ADD) || (req_r.command == CMD_DEC)) && found;

  always_comb begin
    ctrl.cmp_en  = (state_r == ST_CMP);
    ctrl.ins_do  = (state_r == ST_COMMIT) && ins_ok;
    ctrl.upd_do  = (state_r == ST_COMMIT) && upd_ok;
    ctrl.new_key = req_r.key;
    ctrl.new_cnt = (req_r.command == CMD_INSERT) ? req_r.amount : upd_cnt;
  end

  always_comb begin
    state_nxt  = state_r;
    total_nxt  = total_r;
    strobe_nxt = 1'b0;
    rsp_nxt    = rsp_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_CMP;
        end
      end
      ST_CMP:  state_nxt = ST_RED;
      ST_RED:  state_nxt = ST_COMMIT;
      ST_COMMIT: begin
        state_nxt  = ST_IDLE;
        strobe_nxt = 1'b1;
        priority if (req_r.command == CMD_INSERT && found) begin
          rsp_nxt.status      = STAT_DUP;
          rsp_nxt.count_after = old_cnt;
        end else if (req_r.command == CMD_INSERT && full) begin
          rsp_nxt.status      = STAT_FULL;
          rsp_nxt.count_after = '0;
        end else if (req_r.command == CMD_INSERT) begin
          rsp_nxt.status      = STAT_OK;
          rsp_nxt.count_after = req_r.amount;
          total_nxt           = total_r + TOTAL_W'(1);
        end else if (!found) begin
          rsp_nxt.status      = STAT_MISSING;
          rsp_nxt.count_after = '0;
        end else begin
          rsp_nxt.status      = STAT_OK;
          rsp_nxt.count_after = upd_cnt;
        end
        rsp_nxt.occupancy = OCC_W'(total_nxt);
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      total_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      total_r  <= total_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_r <= in_req;
    end
    rsp_r <= rsp_nxt;
  end

  assign out_strobe = strobe_r;
  assign out_rsp    = rsp_r;

`ifndef ASSERT_OFF
  a_strobe_after_commit: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(state_r) == ST_COMMIT)
    else $error("result strobe without a commit cycle");

  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= TOTAL_W'(CAPACITY))
    else $error("occupancy beyond capacity");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> state_r == ST_CMP)
    else $error("accepted request did not start compare");

  a_total_step: assert property (@(posedge clk) disable iff (!rst_n)
    (total_r != $past(total_r)) |-> ($past(ctrl.ins_do) && total_r == $past(total_r) + 1'b1))
    else $error("occupancy changed without an insert");

  a_single_op: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctrl.ins_do && ctrl.upd_do))
    else $error("insert and update in the same commit");
`endif

endmodule

FILE: verif/sorted_key_count_table_checker.sv
module sorted_key_count_table_checker (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic           busy,
  input  skct_pkg::req_t in_req,
  input  logic           out_strobe,
  input  skct_pkg::rsp_t out_rsp,
  output int             mismatches,
  output int             outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import skct_pkg::*;

  logic [KEY_W-1:0] table_key [CAPACITY];
  logic [CNT_W-1:0] table_cnt [CAPACITY];
  int unsigned      fill;
  rsp_t             awaited_rsp [$];
  int               bad;

  initial begin
    fill = 0;
    bad = 0;
    mismatches = 0;
    outstanding = 0;
  end

  function automatic rsp_t update_table(req_t r);
    int unsigned    lo;
    int unsigned    hi;
    int unsigned    mid;
    int unsigned    i;
    logic           hit;
    logic [CNT_W:0] sum;
    rsp_t           res;
    lo = 0;
    hi = fill;
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      if (table_key[mid] < r.key) lo = mid + 1;
      else hi = mid;
    end
    hit = (lo < fill) && (table_key[lo] == r.key);
    res.status = STAT_OK;
    res.count_after = '0;
    if (r.command == CMD_INSERT) begin
      if (hit) begin
        res.status = STAT_DUP;
        res.count_after = table_cnt[lo];
      end else if (fill >= CAPACITY) begin
        res.status = STAT_FULL;
      end else begin
        for (i = fill; i > lo; i--) begin
          table_key[i] = table_key[i-1];
          table_cnt[i] = table_cnt[i-1];
        end
        table_key[lo] = r.key;
        table_cnt[lo] = r.amount;
        fill++;
        res.count_after = r.amount;
      end
    end else if (!hit) begin
      res.status = STAT_MISSING;
    end else begin
      unique case (r.command)
        CMD_ADD: begin
          sum = {1'b0, table_cnt[lo]} + {1'b0, r.amount};
          table_cnt[lo] = sum[CNT_W] ? '1 : sum[CNT_W-1:0];
        end
        CMD_DEC: begin
          if (table_cnt[lo] != '0) table_cnt[lo] = table_cnt[lo] - 1'b1;
        end
        default: ;
      endcase
      res.count_after = table_cnt[lo];
    end
    res.occupancy = OCC_W'(fill);
    return res;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    rsp_t next_rsp;
    if (!rst_n) begin
      awaited_rsp.delete();
      fill = 0;
    end else begin
      if (out_strobe) begin
        if (awaited_rsp.size() == 0) begin
          $display("%0t: result expected none, got status %0d count %0d occupancy %0d",
                   $time, out_rsp.status, out_rsp.count_after, out_rsp.occupancy);
          bad++;
        end else begin
          want = awaited_rsp.pop_front();
          if (out_rsp.status !== want.status) begin
            $display("%0t: status expected %0d, got %0d", $time, want.status, out_rsp.status);
            bad++;
          end
          if (out_rsp.count_after !== want.count_after) begin
            $display("%0t: count_after expected %0d, got %0d",
                     $time, want.count_after, out_rsp.count_after);
            bad++;
          end
          if (out_rsp.occupancy !== want.occupancy) begin
            $display("%0t: occupancy expected %0d, got %0d",
                     $time, want.occupancy, out_rsp.occupancy);
            bad++;
          end
        end
      end
      if (start && !busy) begin
        next_rsp = update_table(in_req);
        awaited_rsp = {awaited_rsp, next_rsp};
      end
    end
    mismatches <= bad;
    outstanding <= awaited_rsp.size();
  end

endmodule

FILE: verif/tb_sorted_key_count_table_core.sv
module tb_sorted_key_count_table_core;
  timeunit 1ns;
  timeprecision 1ps;
  import skct_pkg::*;

  localparam int STALL_LIMIT      = 2000;
  localparam int RANDOM_PER_PHASE = 450;
  localparam int NUM_PHASES       = 4;

  logic clk;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  req_t in_req = '0;
  logic busy;
  logic out_strobe;
  rsp_t out_rsp;

  int               mismatches;
  int               outstanding;
  int               quiet_cycles = 0;
  int               idle_pct = 0;
  logic [KEY_W-1:0] used_keys [$];
  int               phase_idle [NUM_PHASES] = '{0, 85, 0, 29};

  sorted_key_count_table_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_req     (in_req),
    .out_strobe (out_strobe),
    .out_rsp    (out_rsp)
  );

  sorted_key_count_table_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_req      (in_req),
    .out_strobe  (out_strobe),
    .out_rsp     (out_rsp),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("sorted_key_count_table_core regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // hold start high until the request is taken
  task automatic send(input logic [1:0] cmd, input logic [KEY_W-1:0] k,
                      input logic [CNT_W-1:0] amt);
    req_t r;
    r.command = cmd;
    r.key = k;
    r.amount = amt;
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
    start <= 1'b1;
    in_req <= r;
    do @(posedge clk); while (busy);
  endtask

  initial begin
    int               sel;
    logic [1:0]       cmd;
    logic [KEY_W-1:0] k;
    logic [CNT_W-1:0] amt;
    bit               fresh;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    send(CMD_LOOKUP, 16'h1234, 16'h0000);
    send(CMD_ADD,    16'h1234, 16'h0005);
    send(CMD_DEC,    16'h1234, 16'h0000);
    send(CMD_INSERT, 16'h8000, 16'h0001);
    send(CMD_INSERT, 16'h0000, 16'h0000);
    send(CMD_INSERT, 16'hFFFF, 16'hFFFF);
    send(CMD_INSERT, 16'h8000, 16'h0007);
    send(CMD_DEC,    16'h0000, 16'hFFFF);
    send(CMD_ADD,    16'h8000, 16'hFFFF);
    send(CMD_ADD,    16'hFFFF, 16'h0001);
    send(CMD_DEC,    16'hFFFF, 16'h0000);
    send(CMD_LOOKUP, 16'hFFFF, 16'hFFFF);
    send(CMD_DEC,    16'h8000, 16'hFFFF);
    send(CMD_INSERT, 16'h7FFF, 16'h5555);
    send(CMD_INSERT, 16'h0001, 16'hAAAA);
    send(CMD_LOOKUP, 16'h0001, 16'h0000);
    send(CMD_ADD,    16'h0000, 16'h0000);
    send(CMD_LOOKUP, 16'h8001, 16'h0000);
    send(CMD_ADD,    16'h0001, 16'h5555);
    send(CMD_LOOKUP, 16'h0000, 16'h0000);
    used_keys = '{16'h0000, 16'h0001, 16'h7FFF, 16'h8000, 16'hFFFF};

    // drive the table to full, then keep hitting it
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      idle_pct = phase_idle[ph];
      repeat (RANDOM_PER_PHASE) begin
        sel = $urandom_range(0, 99);
        if (sel < 35) cmd = CMD_INSERT;
        else if (sel < 60) cmd = CMD_ADD;
        else if (sel < 85) cmd = CMD_DEC;
        else cmd = CMD_LOOKUP;
        fresh = $urandom_range(0, 99) < ((cmd == CMD_INSERT) ? 70 : 15);
        if (fresh) begin
          if ($urandom_range(0, 19) == 0) k = $urandom_range(0, 1) ? '1 : '0;
          else k = KEY_W'($urandom);
          if (cmd == CMD_INSERT) used_keys = {used_keys, k};
        end else begin
          k = used_keys[$urandom_range(0, used_keys.size() - 1)];
        end
        sel = $urandom_range(0, 9);
        if (sel < 4) amt = CNT_W'($urandom_range(0, 3));
        else if (sel < 8) amt = CNT_W'($urandom);
        else if (sel == 8) amt = '0;
        else amt = '1;
        send(cmd, k, amt);
      end
    end

    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("sorted_key_count_table_core regression: pass");
    end else begin
      $display("sorted_key_count_table_core regression: fail");
    end
    $finish;
  end

endmodule
